// ===== sv/u8sd_pkg.sv =====
// Package with shared types and constants of the UTF-8 stream decoder.
`default_nettype none

package u8sd_pkg;

    localparam int unsigned CpWidth  = 31;
    localparam int unsigned LenWidth = 3;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_NO_CONT  = 2'd2
    } status_t;

    // Classified input byte, passed from the front end to the back end.
    typedef struct packed {
        logic [LenWidth-1:0] lead_len;   // 0 = not a valid lead byte
        logic [6:0]          lead_bits;  // lead payload, already masked
        logic                is_cont;    // byte is of the form 10xxxxxx
        logic [5:0]          cont_bits;  // continuation payload
    } token_t;

    // One decoded result word.
    typedef struct packed {
        logic [CpWidth-1:0]  code_point;
        logic [LenWidth-1:0] seq_length;
        status_t             status;
    } result_t;

endpackage : u8sd_pkg

`default_nettype wire

// ===== sv/u8sd_front.sv =====
// Front end: classifies each raw byte into lead length and payload bits.
`default_nettype none

module u8sd_front
    import u8sd_pkg::*;
(
    input  wire logic [7:0] in_byte,
    output token_t          tok
);

    always_comb
    begin
        tok.is_cont   = (in_byte[7:6] == 2'b10);
        tok.cont_bits = in_byte[5:0];
        case (in_byte) inside
            [8'h00:8'h7F]:
            begin
                tok.lead_len  = 3'd1;
                tok.lead_bits = in_byte[6:0];
            end
            [8'hC0:8'hDF]:
            begin
                tok.lead_len  = 3'd2;
                tok.lead_bits = {2'b00, in_byte[4:0]};
            end
            [8'hE0:8'hEF]:
            begin
                tok.lead_len  = 3'd3;
                tok.lead_bits = {3'b000, in_byte[3:0]};
            end
            [8'hF0:8'hF7]:
            begin
                tok.lead_len  = 3'd4;
                tok.lead_bits = {4'b0000, in_byte[2:0]};
            end
            [8'hF8:8'hFB]:
            begin
                tok.lead_len  = 3'd5;
                tok.lead_bits = {5'b00000, in_byte[1:0]};
            end
            [8'hFC:8'hFD]:
            begin
                tok.lead_len  = 3'd6;
                tok.lead_bits = {6'b000000, in_byte[0]};
            end
            default:
            begin
                // Stray continuation bytes and FE/FF cannot start a sequence.
                tok.lead_len  = 3'd0;
                tok.lead_bits = 7'd0;
            end
        endcase
    end

endmodule : u8sd_front

`default_nettype wire

// ===== sv/u8sd_tok_queue.sv =====
// Two-entry queue of classified bytes between the front and back ends.
`default_nettype none

module u8sd_tok_queue
    import u8sd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire token_t push_tok,
    output logic        full,
    input  wire logic   pop,
    output logic        empty,
    output token_t      head_tok
);

    token_t     mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_tok = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : u8sd_tok_queue

`default_nettype wire

// ===== sv/u8sd_res_queue.sv =====
// Two-entry queue of decoded result words feeding the output ports.
`default_nettype none

module u8sd_res_queue
    import u8sd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_res,
    output logic         full,
    input  wire logic    pop,
    output logic         empty,
    output result_t      head_res
);

    result_t    mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_res = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : u8sd_res_queue

`default_nettype wire

// ===== sv/u8sd_back.sv =====
// Back end: sequence state, accumulation and result generation.
`default_nettype none

module u8sd_back
    import u8sd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   tok_empty,
    input  wire token_t tok,
    output logic        tok_pop,
    input  wire logic   res_full,
    output logic        res_push,
    output result_t     res
);

    logic [CpWidth-1:0]  acc_reg, acc_next;
    logic [LenWidth-1:0] left_reg, left_next;
    logic [LenWidth-1:0] cur_reg, cur_next;
    logic [CpWidth-1:0]  shifted;

    // A word is taken only when its result, if any, has a slot waiting.
    assign tok_pop = !tok_empty && !res_full;
    assign shifted = {acc_reg[CpWidth-7:0], tok.cont_bits};

    always_comb
    begin
        acc_next       = acc_reg;
        left_next      = left_reg;
        cur_next       = cur_reg;
        res_push       = 1'b0;
        res.code_point = '0;
        res.seq_length = '0;
        res.status     = ST_OK;
        if (tok_pop)
        begin
            if (left_reg == 3'd0)
            begin
                if (tok.lead_len == 3'd0)
                begin
                    res_push   = 1'b1;
                    res.status = ST_BAD_LEAD;
                end
                else if (tok.lead_len == 3'd1)
                begin
                    res_push       = 1'b1;
                    res.code_point = {{(CpWidth-7){1'b0}}, tok.lead_bits};
                    res.seq_length = 3'd1;
                end
                else
                begin
                    acc_next  = {{(CpWidth-7){1'b0}}, tok.lead_bits};
                    cur_next  = tok.lead_len;
                    left_next = tok.lead_len - 3'd1;
                end
            end
            else if (!tok.is_cont)
            begin
                // Broken sequence: drop the partial word and this byte.
                res_push   = 1'b1;
                res.status = ST_NO_CONT;
                acc_next   = '0;
                left_next  = '0;
                cur_next   = '0;
            end
            else if (left_reg == 3'd1)
            begin
                res_push       = 1'b1;
                res.code_point = shifted;
                res.seq_length = cur_reg;
                acc_next       = '0;
                left_next      = '0;
                cur_next       = '0;
            end
            else
            begin
                acc_next  = shifted;
                left_next = left_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            left_reg <= '0;
            cur_reg  <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            left_reg <= left_next;
            cur_reg  <= cur_next;
        end
    end

    // At most five continuation bytes are ever outstanding.
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 3'd5)
    else $error("continuation count out of range");

    // An open sequence is always longer than what remains of it.
    a_left_vs_len: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg != 3'd0) |-> (cur_reg > left_reg))
    else $error("remaining count not below sequence length");

    // While waiting for a lead byte, no partial state lingers.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg == 3'd0) |-> (cur_reg == 3'd0 && acc_reg == '0))
    else $error("stale partial state while idle");

    // A result is never pushed into a full output queue.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
    else $error("result pushed into full queue");

endmodule : u8sd_back

`default_nettype wire

// ===== sv/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder (original 1-to-6-byte form).
//
//   Channel   Handshake          Word fields
//   -------   ----------------   -----------------------------------------
//   input     push / full        in_byte[7:0]
//   result    empty / pop        code_point[30:0], seq_length[2:0], status[1:0]
//
// One byte is taken per cycle at a sustained rate. The byte that completes
// a result word is held in the byte queue, and its result word is then
// registered in the result queue, whose head drives the output ports.
// The rate is set by the back end, which retires one queued byte per cycle
// as long as the two-entry result queue has a free slot.
// Reset clears both queues and the sequence state; the decoder then waits
// for a lead byte. A stall on pop fills the result queue, then the byte
// queue, and only then raises full.
`default_nettype none

module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Input word.
    input  wire logic                push,
    output logic                     full,
    input  wire logic [7:0]          in_byte,
    // Result word.
    output logic                     empty,
    input  wire logic                pop,
    output logic [CpWidth-1:0]       code_point,
    output logic [LenWidth-1:0]      seq_length,
    output logic [1:0]               status
);

    token_t  front_tok;
    token_t  head_tok;
    logic    tok_empty;
    logic    tok_pop;
    logic    res_full;
    logic    res_push;
    result_t back_res;
    result_t head_res;

    // The front end classifies each byte without looking at the sequence
    // state, so it never has to wait on the back end beyond queue space.
    u8sd_front u_front (
        .in_byte (in_byte),
        .tok     (front_tok)
    );

    u8sd_tok_queue u_tok_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (front_tok),
        .full     (full),
        .pop      (tok_pop),
        .empty    (tok_empty),
        .head_tok (head_tok)
    );

    // The back end owns the accumulator and decides which bytes produce
    // a result word.
    u8sd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_empty (tok_empty),
        .tok       (head_tok),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    // Result words wait here, so the back end keeps running while the
    // consumer holds off pop, until this queue is full.
    u8sd_res_queue u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .push_res (back_res),
        .full     (res_full),
        .pop      (pop),
        .empty    (empty),
        .head_res (head_res)
    );

    assign code_point = head_res.code_point;
    assign seq_length = head_res.seq_length;
    assign status     = head_res.status;

endmodule : utf8_stream_decoder

`default_nettype wire
